// File: design/rfs_pkg.sv
// Shared widths, register indexes, state codes and control types of the voxel sampler.
package rfs_pkg;

    localparam int COORD_W  = 16;
    localparam int DMAG_W   = 15;
    localparam int FREE_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int STATE_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_COUNT = 3'd3;

    localparam logic [FREE_W-1:0] FREE_COUNT_RESET = 7'd2;

    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_EVAL = 3'd1;
    localparam logic [STATE_W-1:0] S_PLAN = 3'd2;
    localparam logic [STATE_W-1:0] S_MUL  = 3'd3;
    localparam logic [STATE_W-1:0] S_DIV  = 3'd4;
    localparam logic [STATE_W-1:0] S_EMIT = 3'd5;
    localparam logic [STATE_W-1:0] S_ERR  = 3'd6;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
    } t_axis_ctl;

endpackage

// File: design/ray_free_space_voxel_sampler.sv
// Top level of the ray free-space voxel sampler: sequencer, registers and output stage.
//
// Usage: each beat on the hit channel (i_hit_valid/o_hit_ready) carries one hit voxel
// index. The block forms delta = hit - origin, takes the longest absolute axis as the
// sample count n, and sends the up to free_space_count miss cells nearest the hit on
// the cell channel (o_cell_valid/i_cell_ready), marking the last one. A ray with n of
// 32768 or more gives a single beat with too_long and last set and zero cells.
// Configuration beats (i_cfg_valid/o_cfg_ready) write origin x, y, z and the free-space
// count; they are always accepted and are meant to come while the block is idle.
// Timing: o_hit_ready is high only in the idle state. An accepted hit passes through the
// evaluate and plan states. When n is at most the free-space count, cells follow at one
// per cycle while the receiver is ready. Otherwise the start point of each axis is found
// in turn by the one shared divider, through a multiply and a divide state per axis,
// before the cells follow in the same way.
// A stalled receiver holds the output register and the walk waits; the next hit is
// taken once the last cell sits in the output register.
// Reset returns the origin to zero, the free-space count to 2 and the block to idle.
module ray_free_space_voxel_sampler #(
    parameter int MAX_FREE_VOXELS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_hit_valid,
    output logic                               o_hit_ready,
    input  logic signed [rfs_pkg::COORD_W-1:0] i_hit_x,
    input  logic signed [rfs_pkg::COORD_W-1:0] i_hit_y,
    input  logic signed [rfs_pkg::COORD_W-1:0] i_hit_z,
    output logic                               o_cell_valid,
    input  logic                               i_cell_ready,
    output logic signed [rfs_pkg::COORD_W-1:0] o_cell_x,
    output logic signed [rfs_pkg::COORD_W-1:0] o_cell_y,
    output logic signed [rfs_pkg::COORD_W-1:0] o_cell_z,
    output logic                               o_last_of_ray,
    output logic                               o_too_long,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rfs_pkg::COORD_W-1:0]        i_cfg_data
);
    import rfs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FREE_VOXELS + 1);
    localparam int PROD_W = DMAG_W + CNT_W;

    logic [STATE_W-1:0]          r_state, n_state;
    logic [2:0][COORD_W-1:0]     r_origin;
    logic [FREE_W-1:0]           r_free;
    logic [2:0][COORD_W-1:0]     r_hit;
    logic [2:0]                  r_neg;
    logic [2:0][DMAG_W-1:0]      r_dmag;
    logic [COORD_W-1:0]          r_n16;
    logic [1:0]                  r_axis, n_axis;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic [2:0][COORD_W-1:0]     r_cell;
    logic                        r_last;
    logic                        r_too_long;

    logic [2:0]                  d_neg;
    logic [2:0][COORD_W-1:0]     d_mag;
    logic [COORD_W-1:0]          n_max;
    logic [CNT_W-1:0]            f_eff;
    logic                        short_ray;
    logic                        hit_fire;
    logic                        cfg_fire;
    logic                        out_free;
    logic                        load_cell;
    logic                        load_err;
    logic                        div_start;
    logic                        div_done;
    logic [CNT_W-1:0]            div_quot;
    logic [DMAG_W-1:0]           div_rem;
    logic [DMAG_W-1:0]           dmag_sel;
    logic [PROD_W-1:0]           product;
    t_axis_ctl [2:0]             axis_ctl;
    logic [2:0][COORD_W-1:0]     axis_cell;

    assign hit_fire    = i_hit_valid && o_hit_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_hit_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_cell_ready;
    assign load_cell   = (r_state == S_EMIT) && out_free;
    assign load_err    = (r_state == S_ERR) && out_free;
    assign div_start   = (r_state == S_MUL);

    // Delta, its magnitude and the longest axis; registered in the evaluate cycle.
    generate
        for (genvar a = 0; a < 3; a++) begin : g_delta
            logic [COORD_W:0] diff;
            logic [COORD_W:0] mag;
            always_comb begin
                diff     = {r_hit[a][COORD_W-1], r_hit[a]}
                         - {r_origin[a][COORD_W-1], r_origin[a]};
                mag      = diff[COORD_W] ? (~diff + (COORD_W+1)'(1)) : diff;
                d_neg[a] = diff[COORD_W];
                d_mag[a] = mag[COORD_W-1:0];
            end
        end
    endgenerate

    always_comb begin
        n_max = d_mag[0];
        if (d_mag[1] > n_max) begin
            n_max = d_mag[1];
        end
        if (d_mag[2] > n_max) begin
            n_max = d_mag[2];
        end
    end

    always_comb begin
        if (r_free > FREE_W'(MAX_FREE_VOXELS)) begin
            f_eff = CNT_W'(MAX_FREE_VOXELS);
        end else begin
            f_eff = r_free[CNT_W-1:0];
        end
        short_ray = (COORD_W'(f_eff) >= r_n16);
    end

    always_comb begin
        dmag_sel = r_dmag[r_axis];
        product  = PROD_W'(dmag_sel) * PROD_W'(f_eff);
    end

    rfs_div #(
        .QW(CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_n16[DMAG_W-1:0]),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    generate
        for (genvar a = 0; a < 3; a++) begin : g_axis
            always_comb begin
                axis_ctl[a].clear = (r_state == S_PLAN) && short_ray;
                axis_ctl[a].load  = (r_state == S_DIV) && div_done && (r_axis == 2'(a));
                axis_ctl[a].step  = load_cell;
            end

            rfs_axis #(
                .QW(CNT_W)
            ) u_axis (
                .i_clk    (i_clk),
                .i_ctl    (axis_ctl[a]),
                .i_origin (r_origin[a]),
                .i_neg    (r_neg[a]),
                .i_dmag   (r_dmag[a]),
                .i_n      (r_n16[DMAG_W-1:0]),
                .i_qm     (div_quot),
                .i_rm     (div_rem),
                .o_cell   (axis_cell[a])
            );
        end
    endgenerate

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_cell_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (hit_fire) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_PLAN;
            end
            S_PLAN: begin
                n_axis = 2'd0;
                if (r_n16[COORD_W-1]) begin
                    n_state = S_ERR;
                end else if (short_ray) begin
                    n_cnt   = r_n16[CNT_W-1:0];
                    n_state = (r_n16 == '0) ? S_IDLE : S_EMIT;
                end else begin
                    n_cnt   = f_eff;
                    n_state = (f_eff == '0) ? S_IDLE : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_axis == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_EMIT: begin
                if (load_cell) begin
                    n_out_valid = 1'b1;
                    n_cnt       = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (load_err) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 2'd0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_origin    <= '0;
            r_free      <= FREE_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_ORIGIN_X:   r_origin[0] <= i_cfg_data;
                    CFG_ORIGIN_Y:   r_origin[1] <= i_cfg_data;
                    CFG_ORIGIN_Z:   r_origin[2] <= i_cfg_data;
                    CFG_FREE_COUNT: r_free      <= i_cfg_data[FREE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit_fire) begin
            r_hit <= {i_hit_z, i_hit_y, i_hit_x};
        end
        if (r_state == S_EVAL) begin
            r_neg <= d_neg;
            for (int a = 0; a < 3; a++) begin
                // Magnitudes only matter when the ray is not rejected, so they fit 15 bits.
                r_dmag[a] <= d_mag[a][DMAG_W-1:0];
            end
            r_n16 <= n_max;
        end
        if (load_cell) begin
            r_cell     <= axis_cell;
            r_last     <= (r_cnt == CNT_W'(1));
            r_too_long <= 1'b0;
        end else if (load_err) begin
            r_cell     <= '0;
            r_last     <= 1'b1;
            r_too_long <= 1'b1;
        end
    end

    assign o_cell_valid  = r_out_valid;
    assign o_cell_x      = r_cell[0];
    assign o_cell_y      = r_cell[1];
    assign o_cell_z      = r_cell[2];
    assign o_last_of_ray = r_last;
    assign o_too_long    = r_too_long;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && o_too_long) |-> (o_last_of_ray && o_cell_x == '0
            && o_cell_y == '0 && o_cell_z == '0))
        else $error("rejected ray beat is not a lone last beat");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("emitting with no samples left");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_hit_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_fire |=> (r_state == S_EVAL))
        else $error("accepted hit did not start evaluation");

endmodule

// File: design/rfs_div.sv
// Shared restoring divider with a short quotient, one quotient bit per cycle.
module rfs_div #(
    parameter int QW = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rfs_pkg::DMAG_W+QW-1:0]    i_dividend,
    input  logic [rfs_pkg::DMAG_W-1:0]       i_divisor,
    output logic                             o_done,
    output logic [QW-1:0]                    o_quot,
    output logic [rfs_pkg::DMAG_W-1:0]       o_rem
);
    import rfs_pkg::*;

    localparam int RW = DMAG_W + QW;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_dsr, n_dsr;
    logic [QW-1:0] r_quot, n_quot;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic          ge;
    logic [QW:0]   shifted_quot;

    always_comb begin
        ge           = (r_rem >= r_dsr);
        shifted_quot = {r_quot, ge};
        n_rem        = r_rem;
        n_dsr        = r_dsr;
        n_quot       = r_quot;
        n_cnt        = r_cnt;
        n_done       = 1'b0;
        if (i_start) begin
            n_rem  = i_dividend;
            n_dsr  = RW'(i_divisor) << (QW - 1);
            n_quot = '0;
            n_cnt  = CW'(QW);
        end else if (r_cnt != '0) begin
            if (ge) begin
                n_rem = r_rem - r_dsr;
            end
            n_quot = shifted_quot[QW-1:0];
            n_dsr  = r_dsr >> 1;
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DMAG_W-1:0];

endmodule

// File: design/rfs_axis.sv
// One axis of the line walk: quotient and remainder of |delta|*p/n, stepped per sample.
module rfs_axis #(
    parameter int QW = 7
) (
    input  logic                              i_clk,
    input  rfs_pkg::t_axis_ctl                i_ctl,
    input  logic [rfs_pkg::COORD_W-1:0]       i_origin,
    input  logic                              i_neg,
    input  logic [rfs_pkg::DMAG_W-1:0]        i_dmag,
    input  logic [rfs_pkg::DMAG_W-1:0]        i_n,
    input  logic [QW-1:0]                     i_qm,
    input  logic [rfs_pkg::DMAG_W-1:0]        i_rm,
    output logic [rfs_pkg::COORD_W-1:0]       o_cell
);
    import rfs_pkg::*;

    logic [DMAG_W-1:0]  r_q, n_q;
    logic [DMAG_W-1:0]  r_rem, n_rem;
    logic [DMAG_W:0]    sum;
    logic [DMAG_W:0]    wrapped;
    logic               wrap;
    logic               rm_nz;
    logic [COORD_W:0]   mag;
    logic [COORD_W:0]   signed_q;
    logic [COORD_W:0]   total;

    always_comb begin
        sum     = {1'b0, r_rem} + {1'b0, i_dmag};
        wrapped = sum - {1'b0, i_n};
        wrap    = (sum >= {1'b0, i_n});
        rm_nz   = (i_rm != '0);
        n_q     = r_q;
        n_rem   = r_rem;
        if (i_ctl.clear) begin
            n_q   = '0;
            n_rem = '0;
        end else if (i_ctl.load) begin
            // Start sample n-f: |d|*(n-f)/n = |d| - ceil(|d|*f/n).
            n_q   = i_dmag - DMAG_W'(i_qm) - DMAG_W'(rm_nz);
            n_rem = rm_nz ? (i_n - i_rm) : '0;
        end else if (i_ctl.step) begin
            if (wrap) begin
                n_rem = wrapped[DMAG_W-1:0];
                n_q   = r_q + DMAG_W'(1);
            end else begin
                n_rem = sum[DMAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    always_comb begin
        mag      = {2'b00, r_q};
        signed_q = i_neg ? (~mag + (COORD_W+1)'(1)) : mag;
        total    = {i_origin[COORD_W-1], i_origin} + signed_q;
        o_cell   = total[COORD_W-1:0];
    end

endmodule
